>>> src/ics_pkg.sv
package ics_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned PAIR_W  = 9;
  localparam logic [PAIR_W-1:0] PAIR_MAX = '1;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sample_value;
    logic                      is_final;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sorted_value;
    logic [PAIR_W-1:0]         pair_total;
    logic                      dropped_flag;
    logic                      end_of_run;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_INS,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic capture;
    logic drop;
    logic compare;
    logic insert;
    logic emit_load;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic in_final;
    logic held_final;
    logic emit_last;
    logic out_free;
  } dp_st_t;

endpackage

>>> src/ics_ctrl.sv
module ics_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ics_pkg::dp_st_t st_i,
  output ics_pkg::dp_cmd_t cmd_o
);

  ics_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ics_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (!st_i.full) begin
            state_d = ics_pkg::S_CMP;
          end else if (st_i.in_final) begin
            state_d = ics_pkg::S_EMIT;
          end
        end
      end
      ics_pkg::S_CMP: begin
        state_d = ics_pkg::S_INS;
      end
      ics_pkg::S_INS: begin
        state_d = st_i.held_final ? ics_pkg::S_EMIT : ics_pkg::S_IDLE;
      end
      ics_pkg::S_EMIT: begin
        if (st_i.out_free && st_i.emit_last) begin
          state_d = ics_pkg::S_IDLE;
        end
      end
      default: state_d = ics_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ics_pkg::S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        cmd_o.drop    = in_valid_i & st_i.full;
      end
      ics_pkg::S_CMP:  cmd_o.compare   = 1'b1;
      ics_pkg::S_INS:  cmd_o.insert    = 1'b1;
      ics_pkg::S_EMIT: cmd_o.emit_load = st_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ics_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> src/ics_datapath.sv
module ics_datapath #(
  parameter int unsigned MAX_ITEMS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ics_pkg::in_item_t  in_data_i,
  input  ics_pkg::dp_cmd_t   cmd_i,
  output ics_pkg::dp_st_t    st_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output ics_pkg::out_item_t out_data_o
);

  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned SW = ((CW > ics_pkg::PAIR_W) ? CW : ics_pkg::PAIR_W) + 1;
  localparam logic [CW-1:0] FULL_LEVEL = CW'(MAX_ITEMS);

  logic signed [ics_pkg::VALUE_W-1:0] store_q [MAX_ITEMS];
  logic signed [ics_pkg::VALUE_W-1:0] store_d [MAX_ITEMS];
  logic signed [ics_pkg::VALUE_W-1:0] val_q;
  logic                               final_q;
  logic [MAX_ITEMS-1:0]               gt_q, gt_d, valid_mask;
  logic [CW-1:0]                      fill_q, fill_d, ins_pos, greater;
  logic [ics_pkg::PAIR_W-1:0]         pairs_q, pairs_d;
  logic                               ovf_q, ovf_d;
  logic [SW-1:0]                      pair_sum;
  logic                               out_valid_q, out_valid_d;
  ics_pkg::out_item_t                 out_data_q;

  always_comb begin
    for (int i = 0; i < MAX_ITEMS; i++) begin
      valid_mask[i] = (CW'(i) < fill_q);
      gt_d[i]       = valid_mask[i] && (store_q[i] > val_q);
    end
  end

  always_comb begin
    ins_pos = fill_q;
    for (int i = MAX_ITEMS - 1; i >= 0; i--) begin
      if (gt_q[i]) begin
        ins_pos = CW'(i);
      end
    end
  end

  assign greater  = fill_q - ins_pos;
  assign pair_sum = SW'(pairs_q) + SW'(greater);

  always_comb begin
    for (int i = 0; i < MAX_ITEMS; i++) begin
      store_d[i] = store_q[i];
      if (cmd_i.insert) begin
        if (i > 0 && gt_q[(i > 0) ? i - 1 : 0]) begin
          store_d[i] = store_q[(i > 0) ? i - 1 : 0];
        end else if (gt_q[i] || (CW'(i) == fill_q)) begin
          store_d[i] = val_q;
        end
      end else if (cmd_i.emit_load && (i < MAX_ITEMS - 1)) begin
        store_d[i] = store_q[(i < MAX_ITEMS - 1) ? i + 1 : i];
      end
    end
  end

  always_comb begin
    fill_d  = fill_q;
    pairs_d = pairs_q;
    ovf_d   = ovf_q;
    if (cmd_i.drop) begin
      ovf_d = 1'b1;
    end
    if (cmd_i.insert) begin
      fill_d  = fill_q + CW'(1);
      pairs_d = (pair_sum > SW'(ics_pkg::PAIR_MAX)) ? ics_pkg::PAIR_MAX
                                                     : pair_sum[ics_pkg::PAIR_W-1:0];
    end
    if (cmd_i.emit_load) begin
      fill_d = fill_q - CW'(1);
      if (st_o.emit_last) begin
        pairs_d = '0;
        ovf_d   = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      pairs_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      pairs_q     <= pairs_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    store_q <= store_d;
    if (cmd_i.capture) begin
      val_q   <= in_data_i.sample_value;
      final_q <= in_data_i.is_final;
    end
    if (cmd_i.compare) begin
      gt_q <= gt_d;
    end
    if (cmd_i.emit_load) begin
      out_data_q.sorted_value <= store_q[0];
      out_data_q.pair_total   <= pairs_q;
      out_data_q.dropped_flag <= ovf_q;
      out_data_q.end_of_run   <= st_o.emit_last;
    end
  end

  assign st_o.full       = (fill_q == FULL_LEVEL);
  assign st_o.in_final   = in_data_i.is_final;
  assign st_o.held_final = final_q;
  assign st_o.emit_last  = (fill_q == CW'(1));
  assign st_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FULL_LEVEL)
    else $error("fill level beyond capacity");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.insert |=> fill_q == $past(fill_q) + CW'(1))
    else $error("insert did not advance fill level");

  a_gt_thermo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.insert |-> ((gt_q & ~(gt_q >> 1) & (valid_mask >> 1)) == '0))
    else $error("greater mask not contiguous");

  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_load |-> fill_q != '0)
    else $error("emission from empty store");
`endif

endmodule

>>> src/inversion_count_sorter.sv
// Inversion-counting sorter.
// Input channel (in_valid_i/in_ready_o/in_data_i): one signed value per transaction,
// is_final marks the last value of a set. Output channel (out_valid_o/out_ready_i/
// out_data_o): on the final value the stored set leaves in ascending order, every
// transaction carrying the inversion total and drop flag, end_of_run on the last one.
// Flow: a stored value keeps the input closed while it is accepted, compared in
// parallel against all stored entries and shift-inserted; a value dropped because
// the store already holds MAX_ITEMS entries is consumed on accept. After the final
// value, emission (following its insert, or its accept when it was dropped) shifts
// the store out through one output register at one transaction per cycle while the
// receiver is ready. The input stays closed during emission and reopens the cycle
// after the last result is loaded into the output register.
// A receiver stall holds the output register and pauses the drain; nothing is lost.
// Reset empties the store, clears the count and drop flag and the output valid flag.
module inversion_count_sorter #(
  parameter int unsigned MAX_ITEMS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ics_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ics_pkg::out_item_t out_data_o
);

  ics_pkg::dp_cmd_t cmd;
  ics_pkg::dp_st_t  st;

  ics_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  ics_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
